/* rtl/lpht_pkg.sv */
// Package for the linear-probing hash table: field widths, operation and
// status codes, controller state type and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package lpht_pkg;

	localparam int TABLE_SLOTS_DEF = 16;
	localparam int KEY_BITS_DEF    = 16;

	localparam int MODE_W   = 3;
	localparam int KEY_W    = 16;
	localparam int NAME_W   = 64;
	localparam int SIDX_W   = 4;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 4;

	// reciprocal width for the constant modulo (fits for any slot count)
	localparam int RECIP_W  = KEY_W + 1;

	typedef logic [MODE_W-1:0]   mode_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam mode_t MODE_INSERT = 3'd0;
	localparam mode_t MODE_FIND   = 3'd1;
	localparam mode_t MODE_UPDATE = 3'd2;
	localparam mode_t MODE_DELETE = 3'd3;
	localparam mode_t MODE_READ   = 3'd4;

	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_NOT_FOUND = 2'd1;
	localparam status_t STATUS_FULL      = 2'd2;

	typedef enum logic [2:0] {
		CS_CLEAR,
		CS_IDLE,
		CS_HOME1,
		CS_HOME2,
		CS_HOME3,
		CS_PROBE,
		CS_BAD
	} ctrl_state_t;

	typedef struct packed {
		logic clr_wr;    // clear one slot during the reset sweep
		logic start;     // capture the request
		logic home1;     // x * reciprocal
		logic home2;     // quotient * slot count
		logic home3;     // remainder, load probe pointer
		logic issue;     // read the slot at the probe pointer
		logic consume;   // load result, write back
		logic load_bad;  // load not-found result for an unknown mode
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic bad_mode;
		logic issued_all;
		logic rd_vld;
		logic hit;
		logic last;
		logic out_free;
	} dp_status_t;

endpackage

/* rtl/lpht_ctrl.sv */
// Controller for the hash table: clear sweep, home-slot steps, probe loop
// and result hand-off. Depends on lpht_pkg.
`timescale 1ns / 1ps

module lpht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lpht_pkg::dp_status_t sts,
	output lpht_pkg::ctrl_cmd_t  cmd
);

	lpht_pkg::ctrl_state_t state_q, state_d;
	logic outcome;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpht_pkg::CS_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign outcome = sts.rd_vld && (sts.hit || sts.last);

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			lpht_pkg::CS_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = lpht_pkg::CS_IDLE;
				end
			end
			lpht_pkg::CS_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = sts.bad_mode ? lpht_pkg::CS_BAD : lpht_pkg::CS_HOME1;
				end
			end
			lpht_pkg::CS_HOME1: begin
				cmd.home1 = 1'b1;
				state_d   = lpht_pkg::CS_HOME2;
			end
			lpht_pkg::CS_HOME2: begin
				cmd.home2 = 1'b1;
				state_d   = lpht_pkg::CS_HOME3;
			end
			lpht_pkg::CS_HOME3: begin
				cmd.home3 = 1'b1;
				state_d   = lpht_pkg::CS_PROBE;
			end
			lpht_pkg::CS_PROBE: begin
				if (outcome) begin
					// hold the checked slot until the output register frees up
					if (sts.out_free) begin
						cmd.consume = 1'b1;
						state_d     = lpht_pkg::CS_IDLE;
					end
				end else if (!sts.issued_all) begin
					cmd.issue = 1'b1;
				end
			end
			lpht_pkg::CS_BAD: begin
				if (sts.out_free) begin
					cmd.load_bad = 1'b1;
					state_d      = lpht_pkg::CS_IDLE;
				end
			end
			default: begin
				state_d = lpht_pkg::CS_IDLE;
			end
		endcase
	end

endmodule

/* rtl/lpht_dpath.sv */
// Datapath for the hash table: request registers, constant-modulo home unit,
// slot memory with registered read, match logic and output register.
// Depends on lpht_pkg.
`timescale 1ns / 1ps

module lpht_dpath #(
	parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
	parameter int KEY_BITS    = lpht_pkg::KEY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lpht_pkg::ctrl_cmd_t           cmd,
	output lpht_pkg::dp_status_t          sts,
	input  logic [lpht_pkg::MODE_W-1:0]   mode,
	input  logic [lpht_pkg::KEY_W-1:0]    key,
	input  logic [lpht_pkg::NAME_W-1:0]   name_data,
	input  logic [lpht_pkg::SIDX_W-1:0]   slot_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lpht_pkg::STATUS_W-1:0] status,
	output logic [lpht_pkg::SLOT_W-1:0]   slot,
	output logic                          occupied,
	output logic [lpht_pkg::KEY_W-1:0]    key_out,
	output logic [lpht_pkg::NAME_W-1:0]   name_out
);

	localparam int KW     = (KEY_BITS < lpht_pkg::KEY_W) ? KEY_BITS : lpht_pkg::KEY_W;
	localparam int AW     = $clog2(TABLE_SLOTS);
	localparam int CW     = $clog2(TABLE_SLOTS + 1);
	localparam int SH     = lpht_pkg::KEY_W + AW;
	localparam int PW     = lpht_pkg::KEY_W + lpht_pkg::RECIP_W;
	localparam int WW     = 1 + KW + lpht_pkg::NAME_W;
	localparam logic [63:0] RECIP_FULL = ((64'd1 << SH) + 64'(TABLE_SLOTS) - 64'd1)
		/ 64'(TABLE_SLOTS);
	localparam logic [lpht_pkg::RECIP_W-1:0] RECIP = lpht_pkg::RECIP_W'(RECIP_FULL);
	localparam logic [lpht_pkg::KEY_W-1:0] KEY_MASK =
		lpht_pkg::KEY_W'((17'd1 << KW) - 17'd1);
	localparam logic [lpht_pkg::KEY_W-1:0] SLOTS_K = lpht_pkg::KEY_W'(TABLE_SLOTS);
	localparam logic [AW-1:0] LAST_POS = AW'(TABLE_SLOTS - 1);
	localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_SLOTS - 1);
	localparam logic [CW-1:0] ALL_CNT  = CW'(TABLE_SLOTS);

	// request
	lpht_pkg::mode_t              mode_q;
	logic [KW-1:0]                key_q;
	logic [lpht_pkg::NAME_W-1:0]  name_q;
	logic [lpht_pkg::KEY_W-1:0]   xin_q;

	// home unit
	logic [PW-1:0]                prod_s1;
	logic [lpht_pkg::KEY_W-1:0]   quot;
	logic [lpht_pkg::KEY_W-1:0]   qn_s2;
	logic [lpht_pkg::KEY_W-1:0]   diff;
	logic [lpht_pkg::KEY_W-1:0]   rem;

	// probe
	logic [AW-1:0]                pos_q;
	logic [AW-1:0]                pos_nxt;
	logic [CW-1:0]                cnt_q;
	logic [AW-1:0]                chk_pos_s1;
	logic                         rd_vld_s1;
	logic                         last_s1;

	// slot memory: {valid, key, name}
	logic [WW-1:0]                tbl_mem [TABLE_SLOTS];
	logic [WW-1:0]                rdata_q;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic [WW-1:0]                wr_data;
	logic                         r_valid;
	logic [KW-1:0]                r_key;
	logic [lpht_pkg::NAME_W-1:0]  r_name;
	logic                         hit;

	// output register
	logic                          out_valid_q;
	logic [lpht_pkg::STATUS_W-1:0] status_q;
	logic [lpht_pkg::SLOT_W-1:0]   slot_q;
	logic                          occ_q;
	logic [lpht_pkg::KEY_W-1:0]    key_out_q;
	logic [lpht_pkg::NAME_W-1:0]   name_out_q;
	logic [AW+lpht_pkg::SLOT_W-1:0] slot_ext;
	logic                          out_free;

	assign {r_valid, r_key, r_name} = rdata_q;

	assign quot    = lpht_pkg::KEY_W'(prod_s1 >> SH);
	assign diff    = xin_q - qn_s2;
	assign rem     = (diff >= SLOTS_K) ? (diff - SLOTS_K) : diff;
	assign pos_nxt = (pos_q == LAST_POS) ? '0 : (pos_q + AW'(1));

	always_comb begin
		case (mode_q)
			lpht_pkg::MODE_INSERT: hit = !r_valid;
			lpht_pkg::MODE_FIND,
			lpht_pkg::MODE_UPDATE,
			lpht_pkg::MODE_DELETE: hit = r_valid && (r_key == key_q);
			lpht_pkg::MODE_READ:   hit = 1'b1;
			default:               hit = 1'b0;
		endcase
	end

	// write port: clear sweep, or insert/update/delete write-back on a probe hit
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = chk_pos_s1;
		wr_data = {1'b1, key_q, name_q};
		if (cmd.clr_wr) begin
			wr_en   = 1'b1;
			wr_addr = pos_q;
			wr_data = '0;
		end else if (cmd.consume && hit) begin
			case (mode_q)
				lpht_pkg::MODE_INSERT: begin
					wr_en   = 1'b1;
					wr_data = {1'b1, key_q, name_q};
				end
				lpht_pkg::MODE_UPDATE: begin
					wr_en   = 1'b1;
					wr_data = {1'b1, r_key, name_q};
				end
				lpht_pkg::MODE_DELETE: begin
					wr_en   = 1'b1;
					wr_data = {1'b0, r_key, r_name};
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_mem[wr_addr] <= wr_data;
		end
		if (cmd.issue) begin
			rdata_q <= tbl_mem[pos_q];
		end
	end

	// request, home-unit and probe-check payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= mode;
			key_q  <= KW'(key & KEY_MASK);
			name_q <= name_data;
			xin_q  <= (mode == lpht_pkg::MODE_READ) ? lpht_pkg::KEY_W'(slot_index)
				: (key & KEY_MASK);
		end
		if (cmd.home1) begin
			prod_s1 <= PW'(xin_q) * PW'(RECIP);
		end
		if (cmd.home2) begin
			qn_s2 <= lpht_pkg::KEY_W'(32'(quot) * 32'(TABLE_SLOTS));
		end
		if (cmd.issue) begin
			chk_pos_s1 <= pos_q;
			last_s1    <= (cnt_q == LAST_CNT);
		end
	end

	// probe control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.clr_wr || cmd.issue) begin
				pos_q <= pos_nxt;
			end else if (cmd.home3) begin
				pos_q <= AW'(rem);
			end
			if (cmd.home3) begin
				cnt_q <= '0;
			end else if (cmd.issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.issue) begin
				rd_vld_s1 <= 1'b1;
			end else if (cmd.consume || cmd.start) begin
				rd_vld_s1 <= 1'b0;
			end
		end
	end

	// output register
	assign out_free = !out_valid_q || !out_stall;
	assign slot_ext = (AW + lpht_pkg::SLOT_W)'(chk_pos_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.consume || cmd.load_bad) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_bad || (cmd.consume && !hit)) begin
			status_q   <= (cmd.consume && mode_q == lpht_pkg::MODE_INSERT)
				? lpht_pkg::STATUS_FULL : lpht_pkg::STATUS_NOT_FOUND;
			slot_q     <= '0;
			occ_q      <= 1'b0;
			key_out_q  <= '0;
			name_out_q <= '0;
		end else if (cmd.consume) begin
			status_q <= lpht_pkg::STATUS_OK;
			slot_q   <= slot_ext[lpht_pkg::SLOT_W-1:0];
			if (mode_q == lpht_pkg::MODE_INSERT) begin
				occ_q      <= 1'b1;
				key_out_q  <= lpht_pkg::KEY_W'(key_q);
				name_out_q <= name_q;
			end else if (r_valid) begin
				occ_q      <= 1'b1;
				key_out_q  <= lpht_pkg::KEY_W'(r_key);
				name_out_q <= r_name;
			end else begin
				occ_q      <= 1'b0;
				key_out_q  <= '0;
				name_out_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign occupied  = occ_q;
	assign key_out   = key_out_q;
	assign name_out  = name_out_q;

	assign sts.clr_last   = (pos_q == LAST_POS);
	assign sts.bad_mode   = (mode > lpht_pkg::MODE_READ);
	assign sts.issued_all = (cnt_q == ALL_CNT);
	assign sts.rd_vld     = rd_vld_s1;
	assign sts.hit        = hit;
	assign sts.last       = last_s1;
	assign sts.out_free   = out_free;

endmodule

/* rtl/linear_probe_hash_table.sv */
// Top level of the linear-probing hash table: controller plus datapath.
// Depends on lpht_pkg, lpht_ctrl, lpht_dpath.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  request  | in_valid / in_stall   | mode, key, name_data, slot_index
//  result   | out_valid / out_stall | status, slot, occupied, key_out, name_out
//
// One request at a time. Insert, find, update and delete take an accept step,
// the home slot (key mod TABLE_SLOTS by reciprocal multiply), then one memory
// read per probed slot plus a check of the last read. Read-slot reads the
// slot at slot_index mod TABLE_SLOTS; an unknown mode returns not-found.
// After reset a clearing pass over every slot empties the table; in_stall
// stays high meanwhile. A stalled result holds the controller at its last step.
`timescale 1ns / 1ps

module linear_probe_hash_table #(
	parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
	parameter int KEY_BITS    = lpht_pkg::KEY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lpht_pkg::MODE_W-1:0]   mode,
	input  logic [lpht_pkg::KEY_W-1:0]    key,
	input  logic [lpht_pkg::NAME_W-1:0]   name_data,
	input  logic [lpht_pkg::SIDX_W-1:0]   slot_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lpht_pkg::STATUS_W-1:0] status,
	output logic [lpht_pkg::SLOT_W-1:0]   slot,
	output logic                          occupied,
	output logic [lpht_pkg::KEY_W-1:0]    key_out,
	output logic [lpht_pkg::NAME_W-1:0]   name_out
);

	lpht_pkg::ctrl_cmd_t  cmd;
	lpht_pkg::dp_status_t sts;

	lpht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpht_dpath #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.KEY_BITS    (KEY_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.mode       (mode),
		.key        (key),
		.name_data  (name_data),
		.slot_index (slot_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.slot       (slot),
		.occupied   (occupied),
		.key_out    (key_out),
		.name_out   (name_out)
	);

endmodule

/* sim/linear_probe_hash_table_test.sv */
// Testbench for linear_probe_hash_table: directed and random table operations
// checked against a built-in table predictor, with random idling on both sides.
// Depends on lpht_pkg and the linear_probe_hash_table RTL.
`timescale 1ns / 1ps

module linear_probe_hash_table_test;

	localparam int SLOTS = lpht_pkg::TABLE_SLOTS_DEF;
	localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
	localparam lpht_pkg::mode_t MODE_TOP = {lpht_pkg::MODE_W{1'b1}};

	typedef struct packed {
		lpht_pkg::status_t           status;
		logic [lpht_pkg::SLOT_W-1:0] slot;
		logic                        occupied;
		logic [lpht_pkg::KEY_W-1:0]  key_out;
		logic [lpht_pkg::NAME_W-1:0] name_out;
	} table_result_t;

	// shadow of the table plus the queue of predicted results
	class hash_table_scoreboard;
		bit                          used[SLOTS];
		logic [lpht_pkg::KEY_W-1:0]  stored_key[SLOTS];
		logic [lpht_pkg::NAME_W-1:0] stored_name[SLOTS];
		table_result_t               expected_q[$];
		int                          errors;

		function int pending();
			return expected_q.size();
		endfunction

		// random key currently held in the table, 0 if the table is empty
		function bit pick_live_key(output logic [lpht_pkg::KEY_W-1:0] k);
			int live[$];
			for (int i = 0; i < SLOTS; i++)
				if (used[i])
					live.push_back(i);
			k = '0;
			if (live.size() == 0)
				return 1'b0;
			k = stored_key[live[$urandom_range(0, live.size() - 1)]];
			return 1'b1;
		endfunction

		function void note_request(lpht_pkg::mode_t m, logic [lpht_pkg::KEY_W-1:0] k,
			logic [lpht_pkg::NAME_W-1:0] nm, logic [lpht_pkg::SIDX_W-1:0] idx);
			table_result_t r;
			int home;
			int pos;
			int hit;
			r = '0;
			r.status = lpht_pkg::STATUS_NOT_FOUND;
			home = k % SLOTS;
			hit = -1;
			case (m)
				lpht_pkg::MODE_INSERT: begin
					for (int n = 0; n < SLOTS; n++) begin
						pos = (home + n) % SLOTS;
						if (hit < 0 && !used[pos])
							hit = pos;
					end
					if (hit < 0) begin
						r.status = lpht_pkg::STATUS_FULL;
					end else begin
						used[hit] = 1'b1;
						stored_key[hit] = k;
						stored_name[hit] = nm;
						r = '{lpht_pkg::STATUS_OK, hit[lpht_pkg::SLOT_W-1:0], 1'b1, k, nm};
					end
				end
				lpht_pkg::MODE_FIND, lpht_pkg::MODE_UPDATE, lpht_pkg::MODE_DELETE: begin
					// full probe: holes left by deletes do not stop the search
					for (int n = 0; n < SLOTS; n++) begin
						pos = (home + n) % SLOTS;
						if (hit < 0 && used[pos] && stored_key[pos] == k)
							hit = pos;
					end
					if (hit >= 0) begin
						r = '{lpht_pkg::STATUS_OK, hit[lpht_pkg::SLOT_W-1:0], 1'b1,
							stored_key[hit], stored_name[hit]};
						if (m == lpht_pkg::MODE_UPDATE)
							stored_name[hit] = nm;
						else if (m == lpht_pkg::MODE_DELETE)
							used[hit] = 1'b0;
					end
				end
				lpht_pkg::MODE_READ: begin
					pos = idx % SLOTS;
					r.status = lpht_pkg::STATUS_OK;
					r.slot = pos[lpht_pkg::SLOT_W-1:0];
					if (used[pos]) begin
						r.occupied = 1'b1;
						r.key_out = stored_key[pos];
						r.name_out = stored_name[pos];
					end
				end
				default: ;
			endcase
			expected_q.push_back(r);
		endfunction

		task report_mismatch(string what, logic [lpht_pkg::NAME_W-1:0] got,
			logic [lpht_pkg::NAME_W-1:0] want);
			$display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
			errors++;
		endtask

		task check_result(table_result_t got);
			table_result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("result with no request pending", got.name_out, '0);
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", got.status, want.status);
			if (got.slot !== want.slot)
				report_mismatch("slot", got.slot, want.slot);
			if (got.occupied !== want.occupied)
				report_mismatch("occupied", got.occupied, want.occupied);
			if (got.key_out !== want.key_out)
				report_mismatch("key_out", got.key_out, want.key_out);
			if (got.name_out !== want.name_out)
				report_mismatch("name_out", got.name_out, want.name_out);
		endtask
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	lpht_pkg::mode_t               mode = lpht_pkg::MODE_INSERT;
	logic [lpht_pkg::KEY_W-1:0]    key = '0;
	logic [lpht_pkg::NAME_W-1:0]   name_data = '0;
	logic [lpht_pkg::SIDX_W-1:0]   slot_index = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	lpht_pkg::status_t             status;
	logic [lpht_pkg::SLOT_W-1:0]   slot;
	logic                          occupied;
	logic [lpht_pkg::KEY_W-1:0]    key_out;
	logic [lpht_pkg::NAME_W-1:0]   name_out;

	int send_idle_pct = 0;
	int stall_pct = 0;
	logic [lpht_pkg::KEY_W-1:0] key_pool[8];
	hash_table_scoreboard table_sb = new;

	linear_probe_hash_table dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.key        (key),
		.name_data  (name_data),
		.slot_index (slot_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.slot       (slot),
		.occupied   (occupied),
		.key_out    (key_out),
		.name_out   (name_out)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				table_sb.check_result(table_result_t'({status, slot, occupied,
					key_out, name_out}));
			if (in_valid && !in_stall)
				table_sb.note_request(mode, key, name_data, slot_index);
		end
	end

	task automatic drive_request(lpht_pkg::mode_t m, logic [lpht_pkg::KEY_W-1:0] k,
		logic [lpht_pkg::NAME_W-1:0] nm, logic [lpht_pkg::SIDX_W-1:0] idx);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		key <= k;
		name_data <= nm;
		slot_index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// hold off the sender until every outstanding result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (table_sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [lpht_pkg::KEY_W-1:0] random_key();
		if ($urandom_range(0, 99) < 60)
			return key_pool[$urandom_range(0, 7)];
		return lpht_pkg::KEY_W'($urandom);
	endfunction

	// fill_bias leans the mix toward inserts so the table fills up, else drains
	task automatic random_request(bit fill_bias);
		int roll;
		int ins;
		int del;
		lpht_pkg::mode_t m;
		logic [lpht_pkg::KEY_W-1:0] k;
		roll = $urandom_range(0, 99);
		ins = fill_bias ? 45 : 15;
		del = fill_bias ? 10 : 35;
		if (roll < ins)
			m = lpht_pkg::MODE_INSERT;
		else if (roll < ins + del)
			m = lpht_pkg::MODE_DELETE;
		else if (roll < 75)
			m = lpht_pkg::MODE_FIND;
		else if (roll < 87)
			m = lpht_pkg::MODE_UPDATE;
		else if (roll < 96)
			m = lpht_pkg::MODE_READ;
		else
			m = lpht_pkg::mode_t'($urandom_range(lpht_pkg::MODE_READ + 1, MODE_TOP));
		if (m == lpht_pkg::MODE_INSERT || m == lpht_pkg::MODE_READ
			|| $urandom_range(0, 99) >= 75 || !table_sb.pick_live_key(k))
			k = random_key();
		drive_request(m, k, {$urandom, $urandom}, lpht_pkg::SIDX_W'($urandom));
	endtask

	initial begin
		#1_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		// keys clustered on the last two homes so probes wrap around
		for (int i = 0; i < 8; i++) begin
			key_pool[i] = lpht_pkg::KEY_W'($urandom);
			key_pool[i][3:0] = (i % 2 == 0) ? 4'hE : 4'hF;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, wrap, holes after delete, unknown modes, full table
		drive_request(lpht_pkg::MODE_INSERT, '0, '0, '0);
		drive_request(lpht_pkg::MODE_INSERT, '1, '1, '1);
		drive_request(lpht_pkg::MODE_INSERT, 16'h001F, 64'h0123_4567_89AB_CDEF, '0);
		drive_request(lpht_pkg::MODE_FIND, 16'h001F, '0, '0);
		drive_request(lpht_pkg::MODE_DELETE, '0, '0, '0);
		drive_request(lpht_pkg::MODE_FIND, 16'h001F, '0, '0);
		drive_request(lpht_pkg::MODE_READ, '0, '0, '0);
		drive_request(lpht_pkg::MODE_UPDATE, 16'h001F, 64'hA5A5_5A5A_F00F_0FF0, '0);
		drive_request(lpht_pkg::MODE_FIND, 16'h1234, '1, '1);
		drive_request(lpht_pkg::mode_t'(lpht_pkg::MODE_READ + 1), '1, '1, '1);
		drive_request(MODE_TOP, '0, '0, '0);
		for (int i = 0; i < SLOTS - 1; i++)
			drive_request(lpht_pkg::MODE_INSERT, lpht_pkg::KEY_W'(16'h8000 + i),
				{$urandom, $urandom}, '0);
		drive_request(lpht_pkg::MODE_READ, '0, '0, '1);
		drain_results();

		// random phases: no idling, sender idle, receiver stalling, both
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 69 : (phase == 3) ? 31 : 0;
			stall_pct = (phase == 2) ? 69 : (phase == 3) ? 31 : 0;
			for (int n = 0; n < 238; n++)
				random_request((n / 40) % 2 == 0);
			drain_results();
		end

		stall_pct = 0;
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (table_sb.errors == 0 && table_sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/lpht_pkg.sv
rtl/lpht_ctrl.sv
rtl/lpht_dpath.sv
rtl/linear_probe_hash_table.sv
sim/linear_probe_hash_table_test.sv
